>>> rtl/mexp_pkg.sv
// Package: shared constants and the modular add helper for the exponentiation pipeline.
package mexp_pkg;

    // Default and largest supported word width
    localparam int WORD_BITS_DEF = 32;
    localparam int WORD_BITS_MAX = 64;

    // (a + b) mod m for a < m and b < m, without overflow.
    // Callers zero-extend narrower words, so the result stays below m.
    function automatic logic [WORD_BITS_MAX-1:0] add_mod(
        input logic [WORD_BITS_MAX-1:0] a,
        input logic [WORD_BITS_MAX-1:0] b,
        input logic [WORD_BITS_MAX-1:0] m
    );
        logic [WORD_BITS_MAX-1:0] gap;
        gap = m - b;
        add_mod = (a >= gap) ? (a - gap) : (a + b);
    endfunction

endpackage

>>> rtl/modular_exponentiation_32_top.sv
// Top level: fully pipelined base^exponent mod modulus engine.
//
// Usage:
//  - Input stream (s_axis): one transaction carries base_value and exponent.
//  - Output stream (m_axis): one transaction carries the residue.
//  - Config: i_cfg_wr_en writes the modulus (reset value 1); write it only
//    while no transaction is in flight.
//  - Depth: WORD_BITS + WORD_BITS*WORD_BITS register stages; WORD_BITS
//    stages reduce the base, then one stage per bit of each of the
//    WORD_BITS square-and-multiply rounds.
//  - Throughput: one transaction per cycle unless a result waits stalled;
//    each multiply stage takes both shift-and-add products one bit on.
//  - Moduli of 0 and 1 give a residue of 0.
//  - Reset clears every valid bit; payload is not reset.
//  - When the receiver stalls with a result waiting, the whole pipeline,
//    bubbles included, holds and s_axis tready drops; nothing is lost or
//    repeated.
module modular_exponentiation_32_top #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [WORD_BITS-1:0]                 i_cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: base_value, exponent (from bit 0 up), zero padded to bytes
    input  logic [((2*WORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: residue, zero padded to bytes
    output logic [((WORD_BITS+7)/8)*8-1:0]       m_axis_tdata
);

    localparam int OUT_W  = ((WORD_BITS+7)/8)*8;
    localparam int NRED   = WORD_BITS;
    localparam int NMUL   = WORD_BITS*WORD_BITS;

    logic [WORD_BITS-1:0] r_mod;
    logic                 w_ce;

    // Reduction chain
    logic                 red_v   [NRED+1];
    logic [WORD_BITS-1:0] red_acc [NRED+1];
    logic [WORD_BITS-1:0] red_base[NRED+1];
    logic [WORD_BITS-1:0] red_exp [NRED+1];

    // Square-and-multiply chain
    logic                 mul_v   [NMUL+1];
    logic [WORD_BITS-1:0] mul_sq  [NMUL+1];
    logic [WORD_BITS-1:0] mul_res [NMUL+1];
    logic [WORD_BITS-1:0] mul_ar  [NMUL+1];
    logic [WORD_BITS-1:0] mul_as  [NMUL+1];
    logic [WORD_BITS-1:0] mul_exp [NMUL+1];

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WORD_BITS'(1);
        end else if (i_cfg_wr_en) begin
            r_mod <= i_cfg_wr_data;
        end
    end

    // Global advance: hold everything only while a result waits
    assign w_ce          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_ce;

    // Pipeline entry
    assign red_v[0]    = s_axis_tvalid;
    assign red_acc[0]  = '0;
    assign red_base[0] = s_axis_tdata[WORD_BITS-1:0];
    assign red_exp[0]  = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];

    for (genvar k = 0; k < NRED; k++) begin : g_red
        mexp_red_stage #(.WORD_BITS(WORD_BITS), .BIT(WORD_BITS-1-k)) u_red (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_mod   (r_mod),
            .i_valid (red_v[k]),
            .i_acc   (red_acc[k]),
            .i_base  (red_base[k]),
            .i_exp   (red_exp[k]),
            .o_valid (red_v[k+1]),
            .o_acc   (red_acc[k+1]),
            .o_base  (red_base[k+1]),
            .o_exp   (red_exp[k+1])
        );
    end

    // Handoff: reduced base becomes the first square, result starts at one
    assign mul_v[0]   = red_v[NRED];
    assign mul_sq[0]  = red_acc[NRED];
    assign mul_res[0] = WORD_BITS'(1);
    assign mul_ar[0]  = '0;
    assign mul_as[0]  = '0;
    assign mul_exp[0] = red_exp[NRED];

    for (genvar j = 0; j < NMUL; j++) begin : g_mul
        mexp_mul_stage #(
            .WORD_BITS (WORD_BITS),
            .BIT       (WORD_BITS-1-(j % WORD_BITS))
        ) u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_mod   (r_mod),
            .i_valid (mul_v[j]),
            .i_sq    (mul_sq[j]),
            .i_res   (mul_res[j]),
            .i_acc_r (mul_ar[j]),
            .i_acc_s (mul_as[j]),
            .i_exp   (mul_exp[j]),
            .o_valid (mul_v[j+1]),
            .o_sq    (mul_sq[j+1]),
            .o_res   (mul_res[j+1]),
            .o_acc_r (mul_ar[j+1]),
            .o_acc_s (mul_as[j+1]),
            .o_exp   (mul_exp[j+1])
        );
    end

    // Output; moduli of 0 and 1 force a zero residue
    assign m_axis_tvalid = mul_v[NMUL];
    assign m_axis_tdata  = (r_mod <= WORD_BITS'(1)) ? '0 : OUT_W'(mul_res[NMUL]);

endmodule

>>> rtl/mexp_red_stage.sv
// One bit step of the base reduction: acc = (2*acc + base bit) mod m.
module mexp_red_stage #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF,
    parameter int BIT       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic [WORD_BITS-1:0] i_mod,
    input  logic                 i_valid,
    input  logic [WORD_BITS-1:0] i_acc,
    input  logic [WORD_BITS-1:0] i_base,
    input  logic [WORD_BITS-1:0] i_exp,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_acc,
    output logic [WORD_BITS-1:0] o_base,
    output logic [WORD_BITS-1:0] o_exp
);

    localparam int MW = mexp_pkg::WORD_BITS_MAX;

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_acc, r_base, r_exp;
    logic [WORD_BITS-1:0] n_acc;
    logic [MW-1:0]        w_dbl;

    // Double, then fold in the next base bit from the top
    always_comb begin
        w_dbl = mexp_pkg::add_mod(MW'(i_acc), MW'(i_acc), MW'(i_mod));
        n_acc = WORD_BITS'(mexp_pkg::add_mod(w_dbl, MW'(i_base[BIT]), MW'(i_mod)));
    end

    // Valid travels with the stage payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_acc  <= n_acc;
            r_base <= i_base;
            r_exp  <= i_exp;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_base  = r_base;
    assign o_exp   = r_exp;

endmodule

>>> rtl/mexp_mul_stage.sv
// One bit step of the paired modular products res*sq and sq*sq; bit 0 closes a round.
module mexp_mul_stage #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF,
    parameter int BIT       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic [WORD_BITS-1:0] i_mod,
    input  logic                 i_valid,
    input  logic [WORD_BITS-1:0] i_sq,
    input  logic [WORD_BITS-1:0] i_res,
    input  logic [WORD_BITS-1:0] i_acc_r,
    input  logic [WORD_BITS-1:0] i_acc_s,
    input  logic [WORD_BITS-1:0] i_exp,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_sq,
    output logic [WORD_BITS-1:0] o_res,
    output logic [WORD_BITS-1:0] o_acc_r,
    output logic [WORD_BITS-1:0] o_acc_s,
    output logic [WORD_BITS-1:0] o_exp
);

    localparam int MW = mexp_pkg::WORD_BITS_MAX;

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_sq, r_res, r_acc_r, r_acc_s, r_exp;
    logic [WORD_BITS-1:0] n_sq, n_res, n_acc_r, n_acc_s, n_exp;
    logic [MW-1:0]        w_m, w_tr, w_ts;

    always_comb begin
        w_m  = MW'(i_mod);
        // Shift-and-add step for both products, multiplier bit taken from sq
        w_tr = mexp_pkg::add_mod(MW'(i_acc_r), MW'(i_acc_r), w_m);
        w_ts = mexp_pkg::add_mod(MW'(i_acc_s), MW'(i_acc_s), w_m);
        if (i_sq[BIT]) begin
            w_tr = mexp_pkg::add_mod(w_tr, MW'(i_res), w_m);
            w_ts = mexp_pkg::add_mod(w_ts, MW'(i_sq), w_m);
        end
        if (BIT == 0) begin
            // End of round: take the product if this exponent bit is set
            n_sq    = WORD_BITS'(w_ts);
            n_res   = i_exp[0] ? WORD_BITS'(w_tr) : i_res;
            n_exp   = i_exp >> 1;
            n_acc_r = '0;
            n_acc_s = '0;
        end else begin
            n_sq    = i_sq;
            n_res   = i_res;
            n_exp   = i_exp;
            n_acc_r = WORD_BITS'(w_tr);
            n_acc_s = WORD_BITS'(w_ts);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sq    <= n_sq;
            r_res   <= n_res;
            r_acc_r <= n_acc_r;
            r_acc_s <= n_acc_s;
            r_exp   <= n_exp;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
    assign o_res   = r_res;
    assign o_acc_r = r_acc_r;
    assign o_acc_s = r_acc_s;
    assign o_exp   = r_exp;

endmodule

>>> rtl/mexp_checker.sv
// Checker: port-level assertions for the exponentiation engine, bound to the top level.
module mexp_checker #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_wr_en,
    input logic [WORD_BITS-1:0]             i_cfg_wr_data,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [((WORD_BITS+7)/8)*8-1:0]   m_axis_tdata
);

    logic [WORD_BITS-1:0] r_mod;

    // Shadow of the last written modulus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WORD_BITS'(1);
        end else if (i_cfg_wr_en) begin
            r_mod <= i_cfg_wr_data;
        end
    end

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A ready receiver never blocks the input
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled with receiver ready");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Residue below the modulus, zero for trivial moduli
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_mod > WORD_BITS'(1)) ? (m_axis_tdata[WORD_BITS-1:0] < r_mod)
                                                   : (m_axis_tdata == '0)))
        else $error("residue out of range");

endmodule

bind modular_exponentiation_32_top mexp_checker #(.WORD_BITS(WORD_BITS)) u_mexp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/mexp_checker.sv
// Checker for the modular exponentiation engine: predicts residues and compares them.
module mexp_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] modulus_q;
    logic [31:0] residue_q[$];

    // (a * b) mod m, shift-and-add from the top bit, all operands below m
    function automatic logic [31:0] mulmod(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] m);
        logic [32:0] acc;
        acc = '0;
        for (int i = 31; i >= 0; i--) begin
            acc = (acc + acc) % {1'b0, m};
            if (b[i]) begin
                acc = (acc + {1'b0, a}) % {1'b0, m};
            end
        end
        return acc[31:0];
    endfunction

    // base^exp mod m, right-to-left square-and-multiply
    function automatic logic [31:0] powmod(input logic [31:0] b, input logic [31:0] e,
                                           input logic [31:0] m);
        logic [31:0] r;
        logic [31:0] sq;
        if (m <= 32'd1) begin
            return '0;
        end
        r  = 32'd1;
        sq = b % m;
        for (int i = 0; i < 32; i++) begin
            if (e[i]) begin
                r = mulmod(r, sq, m);
            end
            sq = mulmod(sq, sq, m);
        end
        return r;
    endfunction

    assign o_pending = residue_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_q <= 32'd1;
            o_errors  <= 0;
            residue_q.delete();
        end else begin
            // modulus writes
            if (i_cfg_wr_en) begin
                modulus_q <= i_cfg_wr_data;
            end
            // input transaction: predict
            if (s_axis_tvalid && s_axis_tready) begin
                residue_q.push_back(powmod(s_axis_tdata[31:0], s_axis_tdata[63:32], modulus_q));
            end
            // output transaction: compare
            if (m_axis_tvalid && m_axis_tready) begin
                if (residue_q.size() == 0) begin
                    $display("%0t: unexpected residue, expected none, actual %h",
                             $time, m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    if (residue_q[0] !== m_axis_tdata) begin
                        $display("%0t: residue mismatch, expected %h, actual %h",
                                 $time, residue_q[0], m_axis_tdata);
                        o_errors <= o_errors + 1;
                    end
                    void'(residue_q.pop_front());
                end
            end
        end
    end
endmodule

>>> dv/tb_modular_exponentiation_32_top.sv
// Testbench top: drives the modular exponentiation engine and reports the verdict.
module tb_modular_exponentiation_32_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 1056;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    int          errors;
    int          pending;
    bit          rx_calm = 1'b0;
    bit          rx_hold = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    modular_exponentiation_32_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    mexp_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: random stall bursts, one long hold-off on request, none when calm
    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                for (int i = 0; i < 3000; i++) @(posedge i_clk);
                rx_hold = 1'b0;
            end else if (rx_calm || $urandom_range(3) != 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(12, 1);
                m_axis_tready <= 1'b0;
                for (int i = 0; i < n; i++) @(posedge i_clk);
            end
        end
    end

    // Send one transaction, with an optional idle burst before it
    task automatic send_item(input logic [31:0] b, input logic [31:0] e, input bit gaps);
        int n;
        if (gaps && $urandom_range(4) == 0) begin
            n = $urandom_range(12, 1);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e, b};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Wait for every residue, then write the modulus while idle
    task automatic set_modulus(input logic [31:0] m);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(3);
            3: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    logic [31:0] moduli[10] = '{32'd1, 32'hFFFF_FFFB, 32'd2, 32'hFFFF_FFFF, 32'd97,
                                32'h8000_0000, 32'd4294967291, 32'd65537, 32'd3, 32'd0};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset modulus of one, then zero exponent and extremes
        send_item(32'd5, 32'd0, 1'b0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        set_modulus(32'hFFFF_FFFB);
        send_item(32'd0, 32'd0, 1'b0);
        send_item(32'd7, 32'd0, 1'b0);
        send_item(32'd0, 32'd5, 1'b0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFB, 32'd3, 1'b0);
        send_item(32'd2, 32'hFFFF_FFFA, 1'b0);
        send_item(32'h1234_5678, 32'h8000_0001, 1'b0);
        set_modulus(32'd12);
        send_item(32'd10, 32'd7, 1'b0);
        send_item(32'hFFFF_FFFF, 32'd1, 1'b0);
        set_modulus(32'd0);
        send_item(32'd3, 32'd3, 1'b0);
        send_item(32'd3, 32'd0, 1'b0);

        // Long receiver hold-off with the sender pushing
        set_modulus(32'd1_000_003);
        rx_hold = 1'b1;
        for (int i = 0; i < 100; i++) send_item($urandom, $urandom, 1'b0);
        // Let the first result reach the held output, then keep offering
        s_axis_tvalid <= 1'b0;
        repeat (LATENCY + 20) @(posedge i_clk);
        for (int i = 0; i < 20; i++) send_item($urandom, $urandom, 1'b0);

        // Random phases over several moduli
        for (int p = 0; p < 10; p++) begin
            set_modulus(p == 9 ? $urandom : moduli[p]);
            if (p == 8) rx_calm = 1'b1;
            for (int i = 0; i < 80; i++) send_item(rand_word(), rand_word(), !rx_calm);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_modular_exponentiation_32_top: done, clean");
        end else begin
            $display("tb_modular_exponentiation_32_top: done, errors");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("tb_modular_exponentiation_32_top: done, errors");
        $finish;
    end
endmodule

>>> files.f
rtl/mexp_pkg.sv
rtl/mexp_red_stage.sv
rtl/mexp_mul_stage.sv
rtl/modular_exponentiation_32_top.sv
rtl/mexp_checker.sv
dv/mexp_checker.sv
dv/tb_modular_exponentiation_32_top.sv
